@@ design/rcps_pkg.sv @@
// Shared types and constants for the RC pulse capture and smoothing block.
package rcps_pkg;

    // Shared multiplier operand width
    localparam int MUL_W      = 32;
    // Smoothed value: signed Q.8, 24 bits
    localparam int SM_W       = 24;
    // One step field of the result
    localparam int STEP_W     = 32;
    // Step fields carried in one result
    localparam int NUM_OUT    = 3;
    // Captured width storage
    localparam int CAP_W      = 16;
    // Fraction bits of the step gain (Q8.16)
    localparam int SCALE_FRAC = 16;

    // Filter keep factor; the divide by 200 is a reciprocal multiply
    localparam logic [MUL_W-1:0] FILT_KEEP = 32'd199;
    // ceil(2^39 / 200): exact floor(n / 200) for any n below 2^31
    localparam logic [MUL_W-1:0] DIV_RECIP = 32'd2748779070;
    localparam int               DIV_SHIFT = 39;

    // Saturation bounds of the smoothed value
    localparam logic [SM_W-1:0] SM_POS_MAX = 24'h7FFFFF;
    localparam logic [SM_W-1:0] SM_NEG_MAG = 24'h800000;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER     = 3'd0,
        CFG_DEAD_ZONE  = 3'd1,
        CFG_STEP_SCALE = 3'd2,
        CFG_MIN_WIDTH  = 3'd3,
        CFG_MAX_WIDTH  = 3'd4
    } cfg_idx_t;

    // Operand pair handed to the shared multiplier
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

@@ design/rcps_mul.sv @@
// Shared unsigned multiplier with a registered product.
module rcps_mul (
    input  logic                           aclk,
    input  rcps_pkg::mul_req_t             req,
    output logic [2*rcps_pkg::MUL_W-1:0]   prod
);

    logic [2*rcps_pkg::MUL_W-1:0] prod_reg;

    // One product per cycle, available the cycle after the operands
    always_ff @(posedge aclk) begin
        prod_reg <= (2*rcps_pkg::MUL_W)'(req.a) * (2*rcps_pkg::MUL_W)'(req.b);
    end

    assign prod = prod_reg;

endmodule

@@ design/rc_pulse_capture_smoother_unit.sv @@
// RC pulse capture and smoothing: edge timing, low-pass filter, dead zone and step gain.
// Edge request: no result; ready again on the next cycle.
// Update request: a channel with a captured width steps through S_M1, S_SUM, S_M2, S_DIV,
//   S_M3 and S_STEP on the shared multiplier (S_STEP skipped inside the dead zone), an idle
//   channel S_M1 only; the result is valid when S_DONE hands off, input ready again with it.
// A result still waiting holds only the hand-off of the next update, not edge requests.
// Reset (aresetn low, synchronous): configuration registers to defaults, all channel state cleared.
module rc_pulse_capture_smoother_unit #(
    parameter int CHANNELS   = 3,
    parameter int TIMER_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [1:0] channel, [2] pin_level, [3 +: TIMER_BITS] timestamp, zero padded
    input  logic [((3+TIMER_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [0] mode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [31:0] pitch_step, [63:32] roll_step, [95:64] yaw_step
    output logic [rcps_pkg::NUM_OUT*rcps_pkg::STEP_W-1:0] m_axis_tdata,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_addr,
    input  logic [23:0]               cfg_wr_data
);

    localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_IW = $clog2(rcps_pkg::NUM_OUT);
    localparam int CMP_W  = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int SM_W   = rcps_pkg::SM_W;
    localparam int STEP_W = rcps_pkg::STEP_W;
    localparam int MUL_W  = rcps_pkg::MUL_W;

    typedef enum logic [2:0] {
        S_IDLE, S_M1, S_SUM, S_M2, S_DIV, S_M3, S_STEP, S_DONE
    } state_t;

    state_t state_reg;
    logic [OUT_IW-1:0] ch_reg;
    logic              neg_reg;
    logic [30:0]       mag_reg;
    logic [SM_W-1:0]   abs_reg;

    logic [9:0]  center_reg;
    logic [9:0]  dead_zone_reg;
    logic [23:0] step_scale_reg;
    logic [15:0] min_width_reg;
    logic [15:0] max_width_reg;

    logic [TIMER_BITS-1:0]         rise_reg   [CHANNELS];
    logic [TIMER_BITS-1:0]         fall_reg   [CHANNELS];
    logic [rcps_pkg::CAP_W-1:0]    cap_reg    [CHANNELS];
    logic signed [SM_W-1:0]        smooth_reg [CHANNELS];
    logic signed [STEP_W-1:0]      step_reg   [rcps_pkg::NUM_OUT];

    logic                          m_valid_reg;
    logic [rcps_pkg::NUM_OUT*STEP_W-1:0] m_data_reg;

    rcps_pkg::mul_req_t      mul_req;
    logic [2*MUL_W-1:0]      prod;

    // Input fields
    logic [1:0]            in_ch;
    logic                  in_level;
    logic [TIMER_BITS-1:0] in_ts;
    logic                  accept;

    assign in_ch    = s_axis_tdata[1:0];
    assign in_level = s_axis_tdata[2];
    assign in_ts    = s_axis_tdata[3 +: TIMER_BITS];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Edge path: new rise/fall pair, width and window check
    logic [CH_IW-1:0]      e_idx;
    logic                  e_ok;
    logic [TIMER_BITS-1:0] rise_new;
    logic [TIMER_BITS-1:0] fall_new;
    logic [TIMER_BITS-1:0] width_raw;
    logic [CMP_W-1:0]      width;
    logic [CMP_W-1:0]      width_net;
    logic                  width_ok;

    assign e_idx     = CH_IW'(in_ch);
    assign e_ok      = (32'(in_ch) < CHANNELS);
    assign rise_new  = in_level ? in_ts : rise_reg[e_idx];
    assign fall_new  = in_level ? fall_reg[e_idx] : in_ts;
    // Difference wraps at the timer width
    assign width_raw = fall_new - rise_new;
    assign width     = CMP_W'(width_raw);
    assign width_ok  = (width > CMP_W'(min_width_reg)) && (width < CMP_W'(max_width_reg));
    assign width_net = width - CMP_W'(min_width_reg);

    // Update path: current channel
    logic [CH_IW-1:0]        u_idx;
    logic                    u_ok;
    logic signed [SM_W-1:0]  sm_cur;
    logic [SM_W-1:0]         sm_abs;
    logic                    last_ch;

    assign u_idx   = CH_IW'(ch_reg);
    assign u_ok    = (32'(ch_reg) < CHANNELS);
    assign sm_cur  = smooth_reg[u_idx];
    assign sm_abs  = sm_cur[SM_W-1] ? (SM_W)'(-sm_cur) : sm_cur;
    assign last_ch = (ch_reg == OUT_IW'(rcps_pkg::NUM_OUT - 1));

    // Filter sum: +-|sm|*199 + (captured - center)*256, then its magnitude
    logic signed [16:0] cdiff;
    logic signed [33:0] keep_term;
    logic signed [33:0] sum;
    logic signed [33:0] sum_abs;

    assign cdiff     = $signed({1'b0, cap_reg[u_idx]}) - $signed({7'b0, center_reg});
    assign keep_term = neg_reg ? -$signed({3'b0, prod[30:0]}) : $signed({3'b0, prod[30:0]});
    assign sum       = keep_term + $signed({{9{cdiff[16]}}, cdiff, 8'b0});
    assign sum_abs   = sum[33] ? -sum : sum;

    // Quotient by 200 and saturation to 24 bits
    logic [SM_W-1:0]        quot;
    logic [SM_W-1:0]        quot_sat;
    logic signed [SM_W-1:0] sm_new;

    assign quot = prod[rcps_pkg::DIV_SHIFT +: SM_W];
    always_comb begin
        if (neg_reg) begin
            quot_sat = (quot > rcps_pkg::SM_NEG_MAG) ? rcps_pkg::SM_NEG_MAG : quot;
            sm_new   = -$signed(quot_sat);
        end else begin
            quot_sat = (quot > rcps_pkg::SM_POS_MAX) ? rcps_pkg::SM_POS_MAX : quot;
            sm_new   = $signed(quot_sat);
        end
    end

    // Step: |s| <= 2^23 and gain < 2^24, so the scaled magnitude stays below 2^31
    logic [STEP_W-1:0]       step_mag;
    logic signed [STEP_W-1:0] step_val;
    logic                    dz_pass;

    assign step_mag = prod[rcps_pkg::SCALE_FRAC +: STEP_W];
    assign step_val = neg_reg ? -$signed(step_mag) : $signed(step_mag);
    assign dz_pass  = (abs_reg > {6'b0, dead_zone_reg, 8'b0});

    // Shared multiplier operand select
    always_comb begin
        case (state_reg)
            S_M1: begin
                mul_req.a = MUL_W'(sm_abs);
                mul_req.b = rcps_pkg::FILT_KEEP;
            end
            S_M2: begin
                mul_req.a = MUL_W'(mag_reg);
                mul_req.b = rcps_pkg::DIV_RECIP;
            end
            S_M3: begin
                mul_req.a = MUL_W'(abs_reg);
                mul_req.b = MUL_W'(step_scale_reg);
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    rcps_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // Sequencer, channel state, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ch_reg         <= '0;
            neg_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            center_reg     <= 10'd500;
            dead_zone_reg  <= 10'd0;
            step_scale_reg <= 24'd65536;
            min_width_reg  <= 16'd1000;
            max_width_reg  <= 16'd2000;
            for (int i = 0; i < CHANNELS; i++) begin
                rise_reg[i]   <= '0;
                fall_reg[i]   <= '0;
                cap_reg[i]    <= '0;
                smooth_reg[i] <= '0;
            end
        end else begin
            // Configuration writes
            if (cfg_wr_en) begin
                case (rcps_pkg::cfg_idx_t'(cfg_addr))
                    rcps_pkg::CFG_CENTER:     center_reg     <= cfg_wr_data[9:0];
                    rcps_pkg::CFG_DEAD_ZONE:  dead_zone_reg  <= cfg_wr_data[9:0];
                    rcps_pkg::CFG_STEP_SCALE: step_scale_reg <= cfg_wr_data;
                    rcps_pkg::CFG_MIN_WIDTH:  min_width_reg  <= cfg_wr_data[15:0];
                    rcps_pkg::CFG_MAX_WIDTH:  max_width_reg  <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end

            // Result taken; the hand-off state refills it in the same cycle
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser) begin
                            ch_reg    <= '0;
                            state_reg <= S_M1;
                        end else if (e_ok) begin
                            rise_reg[e_idx] <= rise_new;
                            fall_reg[e_idx] <= fall_new;
                            if (width_ok) begin
                                cap_reg[e_idx] <= width_net[rcps_pkg::CAP_W-1:0];
                            end
                        end
                    end
                end
                S_M1: begin
                    // Channel without input (or beyond the channel count) gives zero
                    neg_reg <= sm_cur[SM_W-1];
                    if (!u_ok || cap_reg[u_idx] == '0) begin
                        step_reg[ch_reg] <= '0;
                        if (last_ch) begin
                            state_reg <= S_DONE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_M1;
                        end
                    end else begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    neg_reg   <= sum[33];
                    mag_reg   <= sum_abs[30:0];
                    state_reg <= S_M2;
                end
                S_M2: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    smooth_reg[u_idx] <= sm_new;
                    abs_reg           <= quot_sat;
                    state_reg         <= S_M3;
                end
                S_M3: begin
                    if (dz_pass) begin
                        state_reg <= S_STEP;
                    end else begin
                        step_reg[ch_reg] <= '0;
                        if (last_ch) begin
                            state_reg <= S_DONE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_M1;
                        end
                    end
                end
                S_STEP: begin
                    step_reg[ch_reg] <= step_val;
                    if (last_ch) begin
                        state_reg <= S_DONE;
                    end else begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= S_M1;
                    end
                end
                S_DONE: begin
                    // Hand off once the output register is free
                    if (!m_valid_reg || m_axis_tready) begin
                        for (int k = 0; k < rcps_pkg::NUM_OUT; k++) begin
                            m_data_reg[k*STEP_W +: STEP_W] <= step_reg[k];
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // An update request starts the channel sweep at the first channel
    a_update_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tuser) |=> (state_reg == S_M1 && ch_reg == '0))
        else $error("update request did not start the channel sweep");

    // A new result only comes from the hand-off state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the hand-off state");

    // The quotient is taken from the reciprocal product issued the cycle before
    a_div_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> $past(state_reg == S_M2))
        else $error("quotient read without a reciprocal product");

    // The step is taken from the gain product issued the cycle before
    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP) |-> $past(state_reg == S_M3))
        else $error("step read without a gain product");

endmodule
